// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_NOW(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/gpuf_pkg.sv =====
// Package with types and constants of the grid percolation union-find unit.
`default_nettype none
package gpuf_pkg;
  localparam int unsigned MAX_CELLS = 16384;
  localparam int unsigned NODE_COUNT = MAX_CELLS + 2;
  localparam int unsigned NODE_W = $clog2(NODE_COUNT);
  localparam int unsigned ENTRY_W = NODE_W + 1;
  localparam int unsigned ROW_W = 13;
  localparam int unsigned DIM_W = 14;
  localparam int unsigned DAY_W = 15;
  localparam int unsigned TOTAL_W = 2 * DIM_W;
  localparam int unsigned CNT_W = 15;
  localparam logic [NODE_W-1:0] NODE_TOP = NODE_W'(MAX_CELLS);
  localparam logic [NODE_W-1:0] NODE_BOTTOM = NODE_W'(MAX_CELLS + 1);
  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODE_COUNT - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_CELLS);
  localparam logic [DAY_W-1:0] DAY_MAX = {DAY_W{1'b1}};

  typedef enum logic {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    FIND_SELF   = 2'd0,
    FIND_NB     = 2'd1,
    FIND_TOP    = 2'd2,
    FIND_BOTTOM = 2'd3
  } find_sel_e;

  typedef struct packed {
    logic [ROW_W-1:0] cell_row;
    logic [ROW_W-1:0] cell_col;
    logic             new_problem;
  } in_word_t;

  typedef struct packed {
    logic             crossed;
    logic [DAY_W-1:0] day;
    logic             bad_cell;
  } out_word_t;

  typedef struct packed {
    logic [NODE_W-1:0]  idx;
    logic [NODE_W-1:0]  init_parent;
    logic [TOTAL_W-1:0] total;
    logic               bad;
    logic               has_up;
    logic               has_down;
    logic               has_left;
    logic               has_right;
  } cell_info_t;
endpackage
`default_nettype wire

// ===== rtl/core/gpuf_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module gpuf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16386
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== rtl/core/gpuf_cell_map.sv =====
// Cell index, grid size, range checks and neighbor flags for one cell.
`default_nettype none
module gpuf_cell_map (
  input  wire logic [gpuf_pkg::ROW_W-1:0] cell_row_i,
  input  wire logic [gpuf_pkg::ROW_W-1:0] cell_col_i,
  input  wire logic [gpuf_pkg::DIM_W-1:0] grid_rows_i,
  input  wire logic [gpuf_pkg::DIM_W-1:0] grid_cols_i,
  output gpuf_pkg::cell_info_t            info_o
);
  import gpuf_pkg::*;

  logic [TOTAL_W-1:0] prod;
  logic [TOTAL_W-1:0] total;
  logic [DIM_W-1:0]   row_x;
  logic [DIM_W-1:0]   col_x;
  logic [NODE_W-1:0]  idx;

  assign row_x = {1'b0, cell_row_i};
  assign col_x = {1'b0, cell_col_i};
  assign prod = TOTAL_W'(row_x) * TOTAL_W'(grid_cols_i) + TOTAL_W'(col_x);
  assign total = TOTAL_W'(grid_rows_i) * TOTAL_W'(grid_cols_i);
  assign idx = prod[NODE_W-1:0];

  always_comb begin
    info_o.idx = idx;
    info_o.total = total;
    info_o.bad = (total > TOTAL_MAX) || (row_x >= grid_rows_i) || (col_x >= grid_cols_i);
    info_o.has_up = (cell_row_i != '0);
    info_o.has_down = ((row_x + DIM_W'(1)) < grid_rows_i);
    info_o.has_left = (cell_col_i != '0);
    info_o.has_right = ((col_x + DIM_W'(1)) < grid_cols_i);
    if (cell_row_i == '0) begin
      info_o.init_parent = NODE_TOP;
    end else if (row_x == grid_rows_i - DIM_W'(1)) begin
      info_o.init_parent = NODE_BOTTOM;
    end else begin
      info_o.init_parent = idx;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/grid_percolation_union_find_unit.sv =====
// After reset, and before an item that starts a new problem, a clearing pass walks every
// entry of the parent table; the block takes no word during it.
// A bad cell or a cell already land goes straight to the finds of the top and bottom nodes;
// a new cell is written, and each land neighbor adds two finds (which compress paths) and,
// if the roots differ, a union (on the last one also a top-node read), all on one table port.
// One word at a time; the next is taken once the result is registered. Reset sets 2 by 2.
`default_nettype none
module grid_percolation_union_find_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire gpuf_pkg::in_word_t         in_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output gpuf_pkg::out_word_t             out_word_o,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_index_i,
  input  wire logic [gpuf_pkg::DIM_W-1:0] cfg_data_i
);
  import gpuf_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_CALC   = 12'b000000000100,
    S_LAND   = 12'b000000001000,
    S_NB_SEL = 12'b000000010000,
    S_NB_CHK = 12'b000000100000,
    S_F_WALK = 12'b000001000000,
    S_C_WALK = 12'b000010000000,
    S_C_NEXT = 12'b000100000000,
    S_F_DONE = 12'b001000000000,
    S_DONE   = 12'b010000000000,
    S_TOP_RD = 12'b100000000000
  } state_e;

  state_e             state_q, state_d;
  logic [DIM_W-1:0]   rows_q, cols_q;
  logic [NODE_W-1:0]  clr_q, clr_d;
  logic               pend_q, pend_d;
  in_word_t           item_q, item_d;
  cell_info_t         info_q, info_d, cm_info;
  logic [CNT_W-1:0]   added_q, added_d;
  dir_e               dir_q, dir_d;
  logic [NODE_W-1:0]  nb_q, nb_d;
  logic [NODE_W-1:0]  cur_q, cur_d;
  logic [NODE_W-1:0]  start_q, start_d;
  logic [NODE_W-1:0]  root_q, root_d;
  logic [NODE_W-1:0]  nxt_q, nxt_d;
  logic [NODE_W-1:0]  ra_q, ra_d;
  logic [NODE_W-1:0]  rt_q, rt_d;
  find_sel_e          sel_q, sel_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q, out_word_d;

  logic               mem_we;
  logic [NODE_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  logic [NODE_W-1:0]  rd_parent;
  logic               rd_land;
  logic [NODE_W-1:0]  cols_x;
  logic               nb_ok;
  logic [NODE_W-1:0]  nb_addr;
  logic [TOTAL_W-1:0] diff;

  gpuf_cell_map u_cell_map (
    .cell_row_i (item_q.cell_row),
    .cell_col_i (item_q.cell_col),
    .grid_rows_i(rows_q),
    .grid_cols_i(cols_q),
    .info_o     (cm_info)
  );

  gpuf_ram #(
    .Width(ENTRY_W),
    .Depth(NODE_COUNT)
  ) u_parent_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign rd_parent = mem_rdata[NODE_W-1:0];
  assign rd_land = mem_rdata[ENTRY_W-1];
  assign cols_x = NODE_W'(cols_q);
  assign diff = info_q.total - TOTAL_W'(added_q);

  always_comb begin
    unique case (dir_q)
      DIR_UP: begin
        nb_ok = info_q.has_up;
        nb_addr = info_q.idx - cols_x;
      end
      DIR_DOWN: begin
        nb_ok = info_q.has_down;
        nb_addr = info_q.idx + cols_x;
      end
      DIR_LEFT: begin
        nb_ok = info_q.has_left;
        nb_addr = info_q.idx - NODE_W'(1);
      end
      default: begin
        nb_ok = info_q.has_right;
        nb_addr = info_q.idx + NODE_W'(1);
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    pend_d = pend_q;
    item_d = item_q;
    info_d = info_q;
    added_d = added_q;
    dir_d = dir_q;
    nb_d = nb_q;
    cur_d = cur_q;
    start_d = start_q;
    root_d = root_q;
    nxt_d = nxt_q;
    ra_d = ra_q;
    rt_d = rt_q;
    sel_d = sel_q;
    out_valid_d = out_valid_q;
    out_word_d = out_word_q;
    mem_we = 1'b0;
    mem_addr = cur_q;
    mem_wdata = '0;
    in_ready_o = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_q;
        added_d = '0;
        if (clr_q == NODE_TOP || clr_q == NODE_BOTTOM) begin
          mem_wdata = {1'b1, clr_q};
        end
        if (clr_q == NODE_LAST) begin
          clr_d = '0;
          state_d = pend_q ? S_CALC : S_IDLE;
        end else begin
          clr_d = clr_q + NODE_W'(1);
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_word_i;
          pend_d = 1'b1;
          state_d = in_word_i.new_problem ? S_CLEAR : S_CALC;
        end
      end
      S_CALC: begin
        info_d = cm_info;
        if (cm_info.bad) begin
          cur_d = NODE_TOP;
          start_d = NODE_TOP;
          sel_d = FIND_TOP;
          mem_addr = NODE_TOP;
          state_d = S_F_WALK;
        end else begin
          mem_addr = cm_info.idx;
          state_d = S_LAND;
        end
      end
      S_LAND: begin
        if (rd_land) begin
          cur_d = NODE_TOP;
          start_d = NODE_TOP;
          sel_d = FIND_TOP;
          mem_addr = NODE_TOP;
          state_d = S_F_WALK;
        end else begin
          mem_we = 1'b1;
          mem_addr = info_q.idx;
          mem_wdata = {1'b1, info_q.init_parent};
          added_d = added_q + CNT_W'(1);
          dir_d = DIR_UP;
          state_d = S_NB_SEL;
        end
      end
      S_NB_SEL: begin
        if (nb_ok) begin
          nb_d = nb_addr;
          mem_addr = nb_addr;
          state_d = S_NB_CHK;
        end else if (dir_q == DIR_RIGHT) begin
          cur_d = NODE_TOP;
          start_d = NODE_TOP;
          sel_d = FIND_TOP;
          mem_addr = NODE_TOP;
          state_d = S_F_WALK;
        end else begin
          dir_d = dir_e'(dir_q + 2'd1);
        end
      end
      S_NB_CHK: begin
        if (rd_land) begin
          cur_d = info_q.idx;
          start_d = info_q.idx;
          sel_d = FIND_SELF;
          mem_addr = info_q.idx;
          state_d = S_F_WALK;
        end else if (dir_q == DIR_RIGHT) begin
          cur_d = NODE_TOP;
          start_d = NODE_TOP;
          sel_d = FIND_TOP;
          mem_addr = NODE_TOP;
          state_d = S_F_WALK;
        end else begin
          dir_d = dir_e'(dir_q + 2'd1);
          state_d = S_NB_SEL;
        end
      end
      S_F_WALK: begin
        if (rd_parent == cur_q) begin
          root_d = cur_q;
          if (start_q == cur_q) begin
            state_d = S_F_DONE;
          end else begin
            cur_d = start_q;
            mem_addr = start_q;
            state_d = S_C_WALK;
          end
        end else begin
          cur_d = rd_parent;
          mem_addr = rd_parent;
        end
      end
      S_C_WALK: begin
        mem_we = 1'b1;
        mem_addr = cur_q;
        mem_wdata = {1'b1, root_q};
        nxt_d = rd_parent;
        state_d = S_C_NEXT;
      end
      S_C_NEXT: begin
        cur_d = nxt_q;
        mem_addr = nxt_q;
        state_d = (nxt_q == root_q) ? S_F_DONE : S_C_WALK;
      end
      S_TOP_RD: begin
        mem_addr = NODE_TOP;
        state_d = S_F_WALK;
      end
      S_F_DONE: begin
        unique case (sel_q)
          FIND_SELF: begin
            ra_d = root_q;
            cur_d = nb_q;
            start_d = nb_q;
            sel_d = FIND_NB;
            mem_addr = nb_q;
            state_d = S_F_WALK;
          end
          FIND_NB: begin
            if (ra_q != root_q) begin
              mem_we = 1'b1;
              mem_addr = root_q;
              mem_wdata = {1'b1, ra_q};
            end
            if (dir_q == DIR_RIGHT) begin
              cur_d = NODE_TOP;
              start_d = NODE_TOP;
              sel_d = FIND_TOP;
              if (ra_q == root_q) begin
                mem_addr = NODE_TOP;
                state_d = S_F_WALK;
              end else begin
                state_d = S_TOP_RD;
              end
            end else begin
              dir_d = dir_e'(dir_q + 2'd1);
              state_d = S_NB_SEL;
            end
          end
          FIND_TOP: begin
            rt_d = root_q;
            cur_d = NODE_BOTTOM;
            start_d = NODE_BOTTOM;
            sel_d = FIND_BOTTOM;
            mem_addr = NODE_BOTTOM;
            state_d = S_F_WALK;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_word_d.crossed = (rt_q == root_q);
          out_word_d.bad_cell = info_q.bad;
          if (info_q.total <= TOTAL_W'(added_q)) begin
            out_word_d.day = '0;
          end else if (diff > TOTAL_W'(DAY_MAX)) begin
            out_word_d.day = DAY_MAX;
          end else begin
            out_word_d.day = diff[DAY_W-1:0];
          end
          pend_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      pend_q <= 1'b0;
      added_q <= '0;
      out_valid_q <= 1'b0;
      rows_q <= DIM_W'(2);
      cols_q <= DIM_W'(2);
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      pend_q <= pend_d;
      added_q <= added_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_ROWS: rows_q <= cfg_data_i;
          default: cols_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    info_q <= info_d;
    dir_q <= dir_d;
    nb_q <= nb_d;
    cur_q <= cur_d;
    start_q <= start_d;
    root_q <= root_d;
    nxt_q <= nxt_d;
    ra_q <= ra_d;
    rt_q <= rt_d;
    sel_q <= sel_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o = out_word_q;
endmodule
`default_nettype wire

// ===== rtl/core/gpuf_checker.sv =====
// Port-level checker for the grid percolation union-find unit and its bind.
`default_nettype none
`include "assert_macros.svh"
module gpuf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire gpuf_pkg::in_word_t in_word_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire gpuf_pkg::out_word_t out_word_o
);
  import gpuf_pkg::*;

  logic in_acc;
  logic clr_item;
  logic out_stall;

  assign in_acc = in_valid_i && in_ready_o;
  assign clr_item = in_acc && in_word_i.new_problem;
  assign out_stall = out_valid_o && !out_ready_i;

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_word_o))
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_ready_o)
  `ASSERT_NEXT(a_clear_blocks, clk_i, rst_ni, clr_item, !in_ready_o && !$rose(out_valid_o))
  `ASSERT_NOW(a_ready_with_result, clk_i, rst_ni, $rose(out_valid_o), in_ready_o)
endmodule

bind grid_percolation_union_find_unit gpuf_checker u_gpuf_checker (.*);
`default_nettype wire

// ===== sim/grid_percolation_union_find_unit_tb.sv =====
// Self-checking testbench for the grid percolation union-find unit.
`timescale 1ns / 1ps
`default_nettype none
module grid_percolation_union_find_unit_tb;
  import gpuf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = CFG_ROWS;
  logic [DIM_W-1:0] cfg_data_i = '0;

  grid_percolation_union_find_unit DUT (.*);

  always #1 clk_i = ~clk_i;

  in_word_t pending_cells[$];
  out_word_t expected_words[$];
  int unsigned mismatches = 0;
  int unsigned items_queued = 0;
  int unsigned ready_pct = 100;
  int unsigned gap_max = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  // Local copy of the union-find state.
  int unsigned rows_q = 2;
  int unsigned cols_q = 2;
  int unsigned parent_q[NODE_COUNT];
  bit land_q[MAX_CELLS];
  int unsigned added_q;

  function automatic void wipe_grid();
    for (int i = 0; i < MAX_CELLS; i++) begin
      land_q[i] = 1'b0;
      parent_q[i] = 0;
    end
    parent_q[MAX_CELLS] = MAX_CELLS;
    parent_q[MAX_CELLS + 1] = MAX_CELLS + 1;
    added_q = 0;
  endfunction

  function automatic int unsigned find_root(int unsigned node);
    int unsigned r;
    int unsigned nxt;
    int unsigned steps;
    r = node;
    steps = 0;
    while (r < NODE_COUNT && parent_q[r] != r && steps < NODE_COUNT) begin
      r = parent_q[r];
      steps++;
    end
    if (r >= NODE_COUNT) return node;
    steps = 0;
    while (node != r && node < NODE_COUNT && steps < NODE_COUNT) begin
      nxt = parent_q[node];
      parent_q[node] = r;
      node = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic void link_land(int unsigned self, int unsigned nb);
    int unsigned ra;
    int unsigned rb;
    if (nb < MAX_CELLS && land_q[nb]) begin
      ra = find_root(self);
      rb = find_root(nb);
      if (ra != rb) parent_q[rb] = ra;
    end
  endfunction

  function automatic out_word_t percolate(in_word_t w);
    out_word_t o;
    int unsigned r;
    int unsigned c;
    int unsigned total;
    int unsigned idx;
    int unsigned d;
    r = w.cell_row;
    c = w.cell_col;
    total = rows_q * cols_q;
    o = '0;
    if (w.new_problem) wipe_grid();
    if (total > MAX_CELLS || r >= rows_q || c >= cols_q) begin
      o.bad_cell = 1'b1;
    end else begin
      idx = r * cols_q + c;
      if (!land_q[idx]) begin
        land_q[idx] = 1'b1;
        if (r == 0) parent_q[idx] = MAX_CELLS;
        else if (r == rows_q - 1) parent_q[idx] = MAX_CELLS + 1;
        else parent_q[idx] = idx;
        added_q++;
        if (r > 0) link_land(idx, idx - cols_q);
        if (r + 1 < rows_q) link_land(idx, idx + cols_q);
        if (c > 0) link_land(idx, idx - 1);
        if (c + 1 < cols_q) link_land(idx, idx + 1);
      end
    end
    d = (total > added_q) ? total - added_q : 0;
    if (d > 32767) d = 32767;
    o.day = DAY_W'(d);
    o.crossed = (find_root(MAX_CELLS) == find_root(MAX_CELLS + 1));
    return o;
  endfunction

  // Sender: bursts of words separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_words.push_back(percolate(pending_cells.pop_front()));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_cells.size() > 0) begin
          in_valid_i <= 1'b1;
          in_word_i <= pending_cells[0];
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver and result check.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", out_word_o);
        end else if (out_word_o !== expected_words[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", expected_words[0], out_word_o);
          void'(expected_words.pop_front());
        end else begin
          void'(expected_words.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  task automatic push_cell(int unsigned r, int unsigned c, bit np);
    in_word_t w;
    w.cell_row = ROW_W'(r);
    w.cell_col = ROW_W'(c);
    w.new_problem = np;
    pending_cells.push_back(w);
    items_queued++;
  endtask

  task automatic drain();
    wait (pending_cells.size() == 0 && expected_words.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic write_dim(cfg_reg_e which, int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i <= DIM_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (which == CFG_ROWS) rows_q = value & 16'h3FFF;
    else cols_q = value & 16'h3FFF;
  endtask

  task automatic set_grid(int unsigned r, int unsigned c);
    write_dim(CFG_ROWS, r);
    write_dim(CFG_COLS, c);
  endtask

  // One problem in random order over a small grid, with repeats and noise.
  task automatic random_problem(int unsigned r, int unsigned c);
    int unsigned order[$];
    int unsigned j;
    int unsigned tmp;
    int unsigned n;
    for (int i = 0; i < r * c; i++) order.push_back(i);
    for (int i = r * c - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    n = $urandom_range(r * c / 2, r * c);
    for (int i = 0; i < n; i++) begin
      push_cell(order[i] / c, order[i] % c, i == 0);
      if ($urandom_range(0, 99) < 5) begin
        j = order[$urandom_range(0, i)];
        push_cell(j / c, j % c, 1'b0);
      end
      if ($urandom_range(0, 99) < 5)
        push_cell($urandom_range(0, 8191), $urandom_range(0, 8191), 1'b0);
    end
  endtask

  initial begin
    wipe_grid();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (in_ready_o === 1'b1);

    // Reset grid of two by two: crossing, repeats and cells off the grid.
    push_cell(0, 0, 1'b1);
    push_cell(1, 1, 1'b0);
    push_cell(0, 1, 1'b0);
    push_cell(0, 1, 1'b0);
    push_cell(2, 0, 1'b0);
    push_cell(0, 2, 1'b0);
    push_cell(8191, 8191, 1'b0);
    drain();
    set_grid(0, 2);
    push_cell(0, 0, 1'b1);
    drain();
    set_grid(1, 8192);
    push_cell(0, 8191, 1'b1);
    push_cell(0, 0, 1'b0);
    push_cell(0, 1, 1'b0);
    drain();
    set_grid(8192, 2);
    push_cell(8191, 1, 1'b1);
    push_cell(8190, 1, 1'b0);
    push_cell(0, 0, 1'b0);
    push_cell(4096, 1, 1'b0);
    drain();
    set_grid(16383, 16383);
    push_cell(0, 0, 1'b1);
    drain();
    // Fill three by three, then shrink the grid under the live problem.
    set_grid(3, 3);
    for (int i = 0; i < 9; i++) push_cell(i / 3, i % 3, i == 0);
    drain();
    write_dim(CFG_ROWS, 2);
    push_cell(0, 0, 1'b0);
    drain();

    while (items_queued < 1450) begin
      ready_pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(20, 95);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      set_grid($urandom_range(2, 12), $urandom_range(2, 12));
      random_problem(rows_q, cols_q);
      drain();
    end

    ready_pct = 100;
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("grid_percolation_union_find_unit_tb passed");
    end else begin
      $display("grid_percolation_union_find_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("grid_percolation_union_find_unit_tb failed");
    $finish;
  end
endmodule
`default_nettype wire
